// ===== rtl/core/abkf_pkg.sv =====
// Package for the gyro-bias attitude filter: constants, payload and config types,
// and the small shift/compare helpers shared by the datapath modules.
// No dependencies.
package abkf_pkg;

  localparam int unsigned FRAC_BITS     = 10;
  localparam int unsigned YAW_CAL_SHIFT = 4;
  localparam int          CAL_LIMIT     = 2048;

  localparam int unsigned RAW_W   = 10;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned SHIFT_W = 5;
  localparam int unsigned CFG_IDX_W = 3;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [RAW_W-1:0]         raw_t;
  typedef logic [SHIFT_W-1:0]       shift_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

  localparam word_t ROLL_RATE_BIAS_RST  = word_t'(387072);
  localparam word_t ROLL_POS_BIAS_RST   = word_t'(519168);
  localparam word_t PITCH_RATE_BIAS_RST = word_t'(-317440);
  localparam word_t PITCH_POS_BIAS_RST  = word_t'(510976);
  localparam word_t YAW_RATE_BIAS_RST   = word_t'(499712);

  typedef enum logic [1:0] {
    MODE_HOLD = 2'd0,
    MODE_CAL  = 2'd1,
    MODE_YAW  = 2'd2,
    MODE_FULL = 2'd3
  } mode_e;

  // configuration register indexes
  localparam cfg_idx_t CFG_ROLL_RATE_SHIFT   = 3'd0;
  localparam cfg_idx_t CFG_ROLL_ANGLE_GAIN   = 3'd1;
  localparam cfg_idx_t CFG_ROLL_BIAS_GAIN    = 3'd2;
  localparam cfg_idx_t CFG_ROLL_CAL_SHIFT    = 3'd3;
  localparam cfg_idx_t CFG_PITCH_RATE_SHIFT  = 3'd4;
  localparam cfg_idx_t CFG_PITCH_ANGLE_GAIN  = 3'd5;
  localparam cfg_idx_t CFG_PITCH_BIAS_GAIN   = 3'd6;
  localparam cfg_idx_t CFG_PITCH_CAL_SHIFT   = 3'd7;

  typedef struct packed {
    shift_t rate_shift;
    shift_t angle_gain_shift;
    shift_t bias_gain_shift;
    shift_t cal_shift;
  } axis_cfg_t;

  typedef struct packed {
    axis_cfg_t roll;
    axis_cfg_t pitch;
  } cfg_t;

  typedef struct packed {
    mode_e mode;
    raw_t  accel_x;
    raw_t  accel_y;
    raw_t  gyro_roll;
    raw_t  gyro_pitch;
    raw_t  gyro_yaw;
  } in_t;

  function automatic word_t scale(input raw_t raw);
    scale = word_t'(raw) << FRAC_BITS;
  endfunction

  function automatic word_t asr(input word_t x, input shift_t sh);
    asr = x >>> sh;
  endfunction

  function automatic word_t lowpass(input word_t bias, input word_t sample, input shift_t sh);
    lowpass = bias + asr(sample - bias, sh);
  endfunction

  function automatic logic in_cal_band(input word_t r);
    in_cal_band = (r > word_t'(-CAL_LIMIT)) && (r < word_t'(CAL_LIMIT));
  endfunction

endpackage

// ===== rtl/core/abkf_if.sv =====
// Valid/ready channel interfaces for the attitude filter: sensor set in,
// filter results out. Depends on abkf_pkg.
interface abkf_in_if;
  logic            valid;
  logic            ready;
  abkf_pkg::mode_e mode;
  abkf_pkg::raw_t  accel_x;
  abkf_pkg::raw_t  accel_y;
  abkf_pkg::raw_t  gyro_roll;
  abkf_pkg::raw_t  gyro_pitch;
  abkf_pkg::raw_t  gyro_yaw;

  modport source (output valid, mode, accel_x, accel_y, gyro_roll, gyro_pitch, gyro_yaw,
                  input ready);
  modport sink   (input valid, mode, accel_x, accel_y, gyro_roll, gyro_pitch, gyro_yaw,
                  output ready);
endinterface

interface abkf_out_if;
  logic            valid;
  logic            ready;
  abkf_pkg::word_t roll_angle_out;
  abkf_pkg::word_t pitch_angle_out;
  abkf_pkg::word_t roll_rate_out;
  abkf_pkg::word_t pitch_rate_out;
  abkf_pkg::word_t yaw_rate_out;
  logic            calibrated_flag;

  modport source (output valid, roll_angle_out, pitch_angle_out, roll_rate_out,
                  pitch_rate_out, yaw_rate_out, calibrated_flag, input ready);
  modport sink   (input valid, roll_angle_out, pitch_angle_out, roll_rate_out,
                  pitch_rate_out, yaw_rate_out, calibrated_flag, output ready);
endinterface

// ===== rtl/core/abkf_cfg_regs.sv =====
// Configuration register bank: eight 5-bit shift settings behind a plain write port.
// Depends on abkf_pkg.
module abkf_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  abkf_pkg::cfg_idx_t cfg_idx_i,
  input  abkf_pkg::shift_t   cfg_wdata_i,
  output abkf_pkg::cfg_t     cfg_o
);

  abkf_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        abkf_pkg::CFG_ROLL_RATE_SHIFT:  cfg_d.roll.rate_shift        = cfg_wdata_i;
        abkf_pkg::CFG_ROLL_ANGLE_GAIN:  cfg_d.roll.angle_gain_shift  = cfg_wdata_i;
        abkf_pkg::CFG_ROLL_BIAS_GAIN:   cfg_d.roll.bias_gain_shift   = cfg_wdata_i;
        abkf_pkg::CFG_ROLL_CAL_SHIFT:   cfg_d.roll.cal_shift         = cfg_wdata_i;
        abkf_pkg::CFG_PITCH_RATE_SHIFT: cfg_d.pitch.rate_shift       = cfg_wdata_i;
        abkf_pkg::CFG_PITCH_ANGLE_GAIN: cfg_d.pitch.angle_gain_shift = cfg_wdata_i;
        abkf_pkg::CFG_PITCH_BIAS_GAIN:  cfg_d.pitch.bias_gain_shift  = cfg_wdata_i;
        abkf_pkg::CFG_PITCH_CAL_SHIFT:  cfg_d.pitch.cal_shift        = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/abkf_kalman_axis.sv =====
// One axis of the shift-gain Kalman update: predict angle from the corrected
// rate, then correct angle and rate bias from the position innovation. Depends on abkf_pkg.
module abkf_kalman_axis (
  input  abkf_pkg::word_t     angle_i,
  input  abkf_pkg::word_t     rate_bias_i,
  input  abkf_pkg::word_t     pos_bias_i,
  input  abkf_pkg::word_t     rate_i,
  input  abkf_pkg::word_t     pos_i,
  input  abkf_pkg::axis_cfg_t cfg_i,
  output abkf_pkg::word_t     angle_o,
  output abkf_pkg::word_t     rate_bias_o,
  output abkf_pkg::word_t     rate_o
);

  abkf_pkg::word_t rate, angle_pred, innov;

  always_comb begin
    rate        = rate_i - rate_bias_i;
    angle_pred  = angle_i + abkf_pkg::asr(rate, cfg_i.rate_shift);
    innov       = angle_pred - pos_i + pos_bias_i;
    angle_o     = angle_pred - abkf_pkg::asr(innov, cfg_i.angle_gain_shift);
    rate_bias_o = rate_bias_i + abkf_pkg::asr(innov, cfg_i.bias_gain_shift);
    rate_o      = rate;
  end

endmodule

// ===== rtl/core/attitude_bias_kalman_filter_core.sv =====
// Attitude filter core: gyro-bias tracking for roll and pitch, yaw bias tracker.
// Depends on abkf_pkg, abkf_if, abkf_cfg_regs and abkf_kalman_axis.
//
// Usage:
//   in_i  carries one raw sensor set and a mode per transaction (valid/ready).
//   out_o returns one transaction per input: the five held filter outputs and
//         the calibrated flag, as they stand after that input was processed.
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write the eight shift settings; write only
//         while no transaction is in flight.
// Timing:
//   An accepted set is registered in the input register, then processed in one
//   pass that updates the filter state, loads the result register and sets
//   out_o.valid. One set per cycle is sustained while out_o.ready stays high;
//   the filter state feeds back from its registers, so the next set can use it at once.
// Stall behavior:
//   If out_o.ready is low the result holds, the input register keeps one more
//   set, and in_i.ready drops only once both are full.
// Reset:
//   Bias estimates return to their calibration defaults, angles, held outputs,
//   flag and shift settings clear, and both pipeline stages empty.
module attitude_bias_kalman_filter_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  abkf_in_if.sink            in_i,
  abkf_out_if.source         out_o,
  input  logic               cfg_we_i,
  input  abkf_pkg::cfg_idx_t cfg_idx_i,
  input  abkf_pkg::shift_t   cfg_wdata_i
);

  abkf_pkg::cfg_t cfg;

  abkf_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // input register
  logic           s1_valid_d, s1_valid_q;
  abkf_pkg::in_t  s1_q;
  logic           out_valid_d, out_valid_q;
  logic           adv, in_fire;

  assign adv       = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || adv;
  assign in_fire   = in_i.valid && in_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q.mode       <= in_i.mode;
      s1_q.accel_x    <= in_i.accel_x;
      s1_q.accel_y    <= in_i.accel_y;
      s1_q.gyro_roll  <= in_i.gyro_roll;
      s1_q.gyro_pitch <= in_i.gyro_pitch;
      s1_q.gyro_yaw   <= in_i.gyro_yaw;
    end
  end

  // filter state; held outputs double as the result register
  abkf_pkg::word_t roll_rate_bias_d,  roll_rate_bias_q;
  abkf_pkg::word_t roll_pos_bias_d,   roll_pos_bias_q;
  abkf_pkg::word_t roll_angle_d,      roll_angle_q;
  abkf_pkg::word_t pitch_rate_bias_d, pitch_rate_bias_q;
  abkf_pkg::word_t pitch_pos_bias_d,  pitch_pos_bias_q;
  abkf_pkg::word_t pitch_angle_d,     pitch_angle_q;
  abkf_pkg::word_t yaw_rate_bias_d,   yaw_rate_bias_q;
  abkf_pkg::word_t roll_angle_out_d,  roll_angle_out_q;
  abkf_pkg::word_t pitch_angle_out_d, pitch_angle_out_q;
  abkf_pkg::word_t roll_rate_out_d,   roll_rate_out_q;
  abkf_pkg::word_t pitch_rate_out_d,  pitch_rate_out_q;
  abkf_pkg::word_t yaw_rate_out_d,    yaw_rate_out_q;
  logic            cal_d,             cal_q;

  abkf_pkg::word_t roll_pos, pitch_pos, roll_rate, pitch_rate, yaw_rate;
  abkf_pkg::word_t roll_angle_k, roll_bias_k, roll_rate_k;
  abkf_pkg::word_t pitch_angle_k, pitch_bias_k, pitch_rate_k;
  abkf_pkg::word_t yaw_bias_lp;

  assign roll_pos   = abkf_pkg::scale(s1_q.accel_y);
  assign pitch_pos  = abkf_pkg::scale(s1_q.accel_x);
  assign roll_rate  = abkf_pkg::scale(s1_q.gyro_roll);
  assign pitch_rate = -abkf_pkg::scale(s1_q.gyro_pitch);
  assign yaw_rate   = abkf_pkg::scale(s1_q.gyro_yaw);

  assign yaw_bias_lp = abkf_pkg::lowpass(yaw_rate_bias_q, yaw_rate,
                                         abkf_pkg::shift_t'(abkf_pkg::YAW_CAL_SHIFT));

  abkf_kalman_axis u_roll (
    .angle_i     (roll_angle_q),
    .rate_bias_i (roll_rate_bias_q),
    .pos_bias_i  (roll_pos_bias_q),
    .rate_i      (roll_rate),
    .pos_i       (roll_pos),
    .cfg_i       (cfg.roll),
    .angle_o     (roll_angle_k),
    .rate_bias_o (roll_bias_k),
    .rate_o      (roll_rate_k)
  );

  abkf_kalman_axis u_pitch (
    .angle_i     (pitch_angle_q),
    .rate_bias_i (pitch_rate_bias_q),
    .pos_bias_i  (pitch_pos_bias_q),
    .rate_i      (pitch_rate),
    .pos_i       (pitch_pos),
    .cfg_i       (cfg.pitch),
    .angle_o     (pitch_angle_k),
    .rate_bias_o (pitch_bias_k),
    .rate_o      (pitch_rate_k)
  );

  always_comb begin
    roll_rate_bias_d  = roll_rate_bias_q;
    roll_pos_bias_d   = roll_pos_bias_q;
    roll_angle_d      = roll_angle_q;
    pitch_rate_bias_d = pitch_rate_bias_q;
    pitch_pos_bias_d  = pitch_pos_bias_q;
    pitch_angle_d     = pitch_angle_q;
    yaw_rate_bias_d   = yaw_rate_bias_q;
    roll_angle_out_d  = roll_angle_out_q;
    pitch_angle_out_d = pitch_angle_out_q;
    roll_rate_out_d   = roll_rate_out_q;
    pitch_rate_out_d  = pitch_rate_out_q;
    yaw_rate_out_d    = yaw_rate_out_q;
    cal_d             = cal_q;
    if (adv) begin
      case (s1_q.mode)
        abkf_pkg::MODE_CAL: begin
          roll_rate_bias_d  = abkf_pkg::lowpass(roll_rate_bias_q, roll_rate, cfg.roll.cal_shift);
          roll_pos_bias_d   = abkf_pkg::lowpass(roll_pos_bias_q, roll_pos, cfg.roll.cal_shift);
          pitch_rate_bias_d = abkf_pkg::lowpass(pitch_rate_bias_q, pitch_rate,
                                                cfg.pitch.cal_shift);
          pitch_pos_bias_d  = abkf_pkg::lowpass(pitch_pos_bias_q, pitch_pos,
                                                cfg.pitch.cal_shift);
          yaw_rate_bias_d   = yaw_bias_lp;
          // residuals against the freshly updated biases
          cal_d = abkf_pkg::in_cal_band(roll_pos - roll_pos_bias_d) &&
                  abkf_pkg::in_cal_band(pitch_pos - pitch_pos_bias_d) &&
                  abkf_pkg::in_cal_band(roll_rate - roll_rate_bias_d) &&
                  abkf_pkg::in_cal_band(pitch_rate - pitch_rate_bias_d) &&
                  abkf_pkg::in_cal_band(yaw_rate - yaw_bias_lp);
        end
        abkf_pkg::MODE_YAW: begin
          yaw_rate_bias_d = yaw_bias_lp;
          yaw_rate_out_d  = yaw_rate - yaw_bias_lp;
        end
        abkf_pkg::MODE_FULL: begin
          roll_angle_d      = roll_angle_k;
          roll_rate_bias_d  = roll_bias_k;
          pitch_angle_d     = pitch_angle_k;
          pitch_rate_bias_d = pitch_bias_k;
          yaw_rate_bias_d   = yaw_bias_lp;
          roll_angle_out_d  = roll_angle_k;
          pitch_angle_out_d = pitch_angle_k;
          roll_rate_out_d   = roll_rate_k;
          pitch_rate_out_d  = pitch_rate_k;
          yaw_rate_out_d    = yaw_rate - yaw_bias_lp;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_rate_bias_q  <= abkf_pkg::ROLL_RATE_BIAS_RST;
      roll_pos_bias_q   <= abkf_pkg::ROLL_POS_BIAS_RST;
      roll_angle_q      <= '0;
      pitch_rate_bias_q <= abkf_pkg::PITCH_RATE_BIAS_RST;
      pitch_pos_bias_q  <= abkf_pkg::PITCH_POS_BIAS_RST;
      pitch_angle_q     <= '0;
      yaw_rate_bias_q   <= abkf_pkg::YAW_RATE_BIAS_RST;
      roll_angle_out_q  <= '0;
      pitch_angle_out_q <= '0;
      roll_rate_out_q   <= '0;
      pitch_rate_out_q  <= '0;
      yaw_rate_out_q    <= '0;
      cal_q             <= 1'b0;
    end else begin
      roll_rate_bias_q  <= roll_rate_bias_d;
      roll_pos_bias_q   <= roll_pos_bias_d;
      roll_angle_q      <= roll_angle_d;
      pitch_rate_bias_q <= pitch_rate_bias_d;
      pitch_pos_bias_q  <= pitch_pos_bias_d;
      pitch_angle_q     <= pitch_angle_d;
      yaw_rate_bias_q   <= yaw_rate_bias_d;
      roll_angle_out_q  <= roll_angle_out_d;
      pitch_angle_out_q <= pitch_angle_out_d;
      roll_rate_out_q   <= roll_rate_out_d;
      pitch_rate_out_q  <= pitch_rate_out_d;
      yaw_rate_out_q    <= yaw_rate_out_d;
      cal_q             <= cal_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.roll_angle_out  = roll_angle_out_q;
  assign out_o.pitch_angle_out = pitch_angle_out_q;
  assign out_o.roll_rate_out   = roll_rate_out_q;
  assign out_o.pitch_rate_out  = pitch_rate_out_q;
  assign out_o.yaw_rate_out    = yaw_rate_out_q;
  assign out_o.calibrated_flag = cal_q;

  // hold mode leaves all filter state untouched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s1_q.mode == abkf_pkg::MODE_HOLD) |=>
      ($stable(roll_angle_q) && $stable(pitch_angle_q) && $stable(yaw_rate_bias_q) &&
       $stable(roll_rate_bias_q) && $stable(pitch_rate_bias_q)))
    else $error("filter state changed on a hold transaction");

  // flag moves only on a calibration transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(adv && s1_q.mode == abkf_pkg::MODE_CAL) |=> $stable(cal_q))
    else $error("calibrated flag changed outside calibration");

  // a new result appears only after a set left the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result valid without a pending input");

  // output register stalled: held results must not be overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> $stable(yaw_rate_out_q) && $stable(roll_angle_out_q))
    else $error("stalled result overwritten");

endmodule
